// ===== design/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and the control store of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int EST_W      = 32;
  localparam int COV_W      = 32;
  localparam int GAIN_BITS  = 16;
  localparam int GAIN_W     = GAIN_BITS + 1;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W     = 3;
  localparam int DIV_CNT_W  = 5;

  localparam logic [GAIN_W-1:0]    GAIN_ONE      = GAIN_W'(1) << GAIN_BITS;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST      = DIV_CNT_W'(GAIN_BITS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_EST   = 8'd3;

  localparam logic [COV_W-1:0] RST_PROC_NOISE = 32'd655;
  localparam logic [COV_W-1:0] RST_MEAS_NOISE = 32'd65536;
  localparam logic [COV_W-1:0] RST_INIT_COV   = 32'd65536;
  localparam logic [EST_W-1:0] RST_INIT_EST   = 32'd0;

  // datapath operations
  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_PRED = 3'd1;
  localparam logic [2:0] OP_DEN  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_MUL1 = 3'd4;
  localparam logic [2:0] OP_MUL2 = 3'd5;
  localparam logic [2:0] OP_FIN  = 3'd6;

  // sequencing conditions
  localparam logic [2:0] C_NEXT     = 3'd0;
  localparam logic [2:0] C_WAIT_IN  = 3'd1;
  localparam logic [2:0] C_JMP_DEN0 = 3'd2;
  localparam logic [2:0] C_LOOP_DIV = 3'd3;
  localparam logic [2:0] C_WAIT_OUT = 3'd4;

  // step addresses
  localparam logic [STEP_W-1:0] S_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] S_PRED = 3'd1;
  localparam logic [STEP_W-1:0] S_DEN  = 3'd2;
  localparam logic [STEP_W-1:0] S_DIV  = 3'd3;
  localparam logic [STEP_W-1:0] S_MUL1 = 3'd4;
  localparam logic [STEP_W-1:0] S_MUL2 = 3'd5;
  localparam logic [STEP_W-1:0] S_FIN  = 3'd6;

  typedef struct packed {
    logic              in_rdy;
    logic [2:0]        op;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic den_zero;
    logic div_last;
    logic out_busy;
  } flags_t;

  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      S_IDLE:  w = '{in_rdy: 1'b1, op: OP_NOP,  cond: C_WAIT_IN,  target: S_IDLE};
      S_PRED:  w = '{in_rdy: 1'b0, op: OP_PRED, cond: C_NEXT,     target: S_IDLE};
      S_DEN:   w = '{in_rdy: 1'b0, op: OP_DEN,  cond: C_JMP_DEN0, target: S_MUL1};
      S_DIV:   w = '{in_rdy: 1'b0, op: OP_DIV,  cond: C_LOOP_DIV, target: S_DIV};
      S_MUL1:  w = '{in_rdy: 1'b0, op: OP_MUL1, cond: C_NEXT,     target: S_IDLE};
      S_MUL2:  w = '{in_rdy: 1'b0, op: OP_MUL2, cond: C_NEXT,     target: S_IDLE};
      S_FIN:   w = '{in_rdy: 1'b0, op: OP_FIN,  cond: C_WAIT_OUT, target: S_IDLE};
      default: w = '{in_rdy: 1'b0, op: OP_NOP,  cond: C_NEXT,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== design/skf_in_if.sv =====
// ----------------------------------------------------------------------------
// skf_in_if
// Sample channel: valid/ready handshake carrying one raw measurement.
// ----------------------------------------------------------------------------
interface skf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

// ===== design/skf_out_if.sv =====
// ----------------------------------------------------------------------------
// skf_out_if
// Result channel: filtered estimate, gain used and updated covariance.
// ----------------------------------------------------------------------------
interface skf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [skf_pkg::EST_W-1:0]   estimate;
  logic        [skf_pkg::GAIN_W-1:0]  gain;
  logic        [skf_pkg::COV_W-1:0]   covariance;

  modport source (output valid, output estimate, output gain, output covariance, input ready);
  modport sink   (input valid, input estimate, input gain, input covariance, output ready);
endinterface

// ===== design/skf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// skf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface skf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [skf_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [skf_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/skf_seq.sv =====
// ----------------------------------------------------------------------------
// skf_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module skf_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  skf_pkg::flags_t  flags,
  output skf_pkg::ctrl_t   ctrl
);
  import skf_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [STEP_W-1:0] step_inc;

  assign ctrl     = ucode_rom(step_r);
  assign step_inc = step_r + STEP_W'(1);

  always_comb begin
    case (ctrl.cond)
      C_NEXT:     step_nxt = step_inc;
      C_WAIT_IN:  step_nxt = flags.in_fire ? step_inc : step_r;
      C_JMP_DEN0: step_nxt = flags.den_zero ? ctrl.target : step_inc;
      C_LOOP_DIV: step_nxt = flags.div_last ? step_inc : ctrl.target;
      C_WAIT_OUT: step_nxt = flags.out_busy ? step_r : ctrl.target;
      default:    step_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== design/skf_dp.sv =====
// ----------------------------------------------------------------------------
// skf_dp
// Filter datapath: config registers, state, restoring divider and multipliers.
// ----------------------------------------------------------------------------
module skf_dp #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  skf_pkg::ctrl_t  ctrl,
  output skf_pkg::flags_t flags,
  skf_in_if.sink          in_ch,
  skf_out_if.source       out_ch,
  skf_cfg_if.sink         cfg_ch
);
  import skf_pkg::*;

  localparam int REM_W  = COV_W + 2;
  localparam int DEN_W  = COV_W + 1;
  localparam int DIFF_W = EST_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int SUM_W  = EST_W + 4;
  localparam int PC_W   = GAIN_W + COV_W;

  // configuration
  logic [COV_W-1:0] proc_noise_r, meas_noise_r;

  // filter state
  logic signed [EST_W-1:0] est_r;
  logic [COV_W-1:0]        cov_r;

  // working registers
  logic signed [SAMPLE_BITS-1:0] meas_r;
  logic [COV_W-1:0]              nowp_r;
  logic signed [DIFF_W-1:0]      diff_r;
  logic [DEN_W-1:0]              den_r;
  logic [REM_W-1:0]              rem_r;
  logic [GAIN_W-1:0]             quo_r;
  logic [DIV_CNT_W-1:0]          cnt_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic [PC_W-1:0]               pcov_r;

  logic                          out_valid_r;
  logic signed [EST_W-1:0]       out_est_r;
  logic [GAIN_W-1:0]             out_gain_r;
  logic [COV_W-1:0]              out_cov_r;

  logic                     in_fire, cfg_fire, out_busy, fin_go;
  logic signed [63:0]       samp_sh;
  logic signed [EST_W-1:0]  meas_fx;
  logic [COV_W:0]           pred_sum;
  logic [COV_W-1:0]         nowp_nxt;
  logic [DEN_W-1:0]         den_nxt;
  logic                     div_bit;
  logic [REM_W-1:0]         rem_sub;
  logic signed [PROD_W-1:0] gain_ext, diff_ext;
  logic signed [SUM_W-1:0]  est_sum;
  logic signed [EST_W-1:0]  est_sat;
  logic [GAIN_W-1:0]        one_minus_g;

  assign in_ch.ready   = ctrl.in_rdy;
  assign cfg_ch.ready  = 1'b1;
  assign in_fire       = in_ch.valid && ctrl.in_rdy;
  assign cfg_fire      = cfg_ch.valid;
  assign out_busy      = out_valid_r && !out_ch.ready;
  assign fin_go        = (ctrl.op == OP_FIN) && !out_busy;

  // sample to fixed point, saturated to the estimate range
  assign samp_sh = 64'(meas_r) <<< FRAC_BITS;
  always_comb begin
    if (samp_sh > 64'sh7FFF_FFFF) begin
      meas_fx = {1'b0, {(EST_W-1){1'b1}}};
    end else if (samp_sh < -64'sh8000_0000) begin
      meas_fx = {1'b1, {(EST_W-1){1'b0}}};
    end else begin
      meas_fx = samp_sh[EST_W-1:0];
    end
  end

  // predicted covariance, saturated
  assign pred_sum = {1'b0, cov_r} + {1'b0, proc_noise_r};
  assign nowp_nxt = pred_sum[COV_W] ? {COV_W{1'b1}} : pred_sum[COV_W-1:0];
  assign den_nxt  = {1'b0, nowp_r} + {1'b0, meas_noise_r};

  // one restoring division step per cycle
  assign div_bit = rem_r >= {1'b0, den_r};
  assign rem_sub = div_bit ? (rem_r - {1'b0, den_r}) : rem_r;

  assign gain_ext = PROD_W'(signed'({1'b0, quo_r}));
  assign diff_ext = PROD_W'(diff_r);

  // estimate plus floor-shifted correction
  assign est_sum = SUM_W'(est_r) + SUM_W'(prod_r >>> GAIN_BITS);
  always_comb begin
    if (est_sum > SUM_W'(64'sh7FFF_FFFF)) begin
      est_sat = {1'b0, {(EST_W-1){1'b1}}};
    end else if (est_sum < -SUM_W'(64'sh8000_0000)) begin
      est_sat = {1'b1, {(EST_W-1){1'b0}}};
    end else begin
      est_sat = est_sum[EST_W-1:0];
    end
  end

  assign one_minus_g = GAIN_ONE - quo_r;

  assign flags.in_fire  = in_fire;
  assign flags.den_zero = (den_nxt == '0);
  assign flags.div_last = (cnt_r == DIV_LAST);
  assign flags.out_busy = out_busy;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      meas_r <= in_ch.measurement;
    end
    case (ctrl.op)
      OP_PRED: begin
        nowp_r <= nowp_nxt;
        diff_r <= DIFF_W'(meas_fx) - DIFF_W'(est_r);
      end
      OP_DEN: begin
        den_r <= den_nxt;
        rem_r <= REM_W'(nowp_r);
        quo_r <= '0;
        cnt_r <= '0;
      end
      OP_DIV: begin
        rem_r <= {rem_sub[REM_W-2:0], 1'b0};
        quo_r <= {quo_r[GAIN_W-2:0], div_bit};
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
      OP_MUL1: begin
        prod_r <= gain_ext * diff_ext;
      end
      OP_MUL2: begin
        pcov_r <= PC_W'(one_minus_g) * PC_W'(nowp_r);
      end
      default: begin
      end
    endcase
    if (fin_go) begin
      out_est_r  <= est_r;
      out_gain_r <= quo_r;
      out_cov_r  <= pcov_r[GAIN_BITS +: COV_W];
    end
  end

  // control, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_noise_r <= RST_PROC_NOISE;
      meas_noise_r <= RST_MEAS_NOISE;
      est_r        <= signed'(RST_INIT_EST);
      cov_r        <= RST_INIT_COV;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctrl.op == OP_MUL2) begin
        est_r <= est_sat;
      end
      if (fin_go) begin
        cov_r <= pcov_r[GAIN_BITS +: COV_W];
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // initial covariance and estimate only matter as a restart of the state
      if (cfg_fire) begin
        case (cfg_ch.reg_index)
          REG_PROC_NOISE: proc_noise_r <= cfg_ch.wdata;
          REG_MEAS_NOISE: meas_noise_r <= cfg_ch.wdata;
          REG_INIT_COV: begin
            cov_r <= cfg_ch.wdata;
          end
          REG_INIT_EST: begin
            est_r <= signed'(cfg_ch.wdata);
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.estimate   = out_est_r;
  assign out_ch.gain       = out_gain_r;
  assign out_ch.covariance = out_cov_r;

endmodule

// ===== design/scalar_kalman_filter_top.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// One-dimensional fixed-point Kalman filter, microcoded over a shared datapath.
// ----------------------------------------------------------------------------
// in_ch  : one signed raw sample per transaction (valid/ready)
// out_ch : one result per sample: estimate (Q16.16), gain (Q1.16), covariance
// cfg_ch : register writes, index 0 process noise, 1 measurement noise,
//          2 initial covariance, 3 initial estimate; always ready, writes to
//          2 and 3 also reload the stored covariance / estimate
// steps: after the sample transaction the sequencer runs predict, the
//          denominator, the gain divide (a restoring loop of 17 single-bit
//          steps), the two multiplies and the final step that registers the
//          result; with a zero denominator the divider is skipped
// intake: a sample is taken only while the sequencer sits in its idle step,
//          so a new sample waits until the last one has left the final step
// the result register holds a finished result, so the next sample is
//          accepted and worked on while the receiver stalls; the final step
//          waits only if that register is still full
// reset: synchronous, active low; the configuration and filter state
//          return to their default values and no result is pending
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  skf_in_if.sink     in_ch,
  skf_out_if.source  out_ch,
  skf_cfg_if.sink    cfg_ch
);
  import skf_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  skf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  skf_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .flags  (flags),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule

// ===== sim/skf_result_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_result_check
// Watches the sample, result and register channels of the scalar Kalman
// filter. It keeps its own copy of the filter state and registers and works
// out the expected estimate, gain and covariance for every accepted sample.
// Each accepted result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module skf_result_check (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [15:0]                   in_measurement,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [skf_pkg::EST_W-1:0]     out_estimate,
  input  logic        [skf_pkg::GAIN_W-1:0]    out_gain,
  input  logic        [skf_pkg::COV_W-1:0]     out_covariance,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic        [skf_pkg::CFG_IDX_W-1:0] cfg_reg_index,
  input  logic        [skf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                   mismatches,
  output int                                   outstanding
);
  import skf_pkg::*;

  localparam int     FRAC    = 16;
  localparam longint EST_MAX = 64'sh7FFF_FFFF;
  localparam longint EST_MIN = -64'sh8000_0000;
  localparam longint unsigned COV_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic signed [EST_W-1:0] estimate;
    logic        [GAIN_W-1:0] gain;
    logic        [COV_W-1:0]  covariance;
  } filter_result_t;

  logic        [COV_W-1:0] proc_noise;
  logic        [COV_W-1:0] meas_noise;
  logic        [COV_W-1:0] cov_state;
  logic signed [EST_W-1:0] est_state;
  filter_result_t          expected_results[$];
  int                      error_count = 0;

  function automatic logic signed [EST_W-1:0] clamp_est(input longint v);
    if (v > EST_MAX) return EST_MAX[EST_W-1:0];
    if (v < EST_MIN) return EST_MIN[EST_W-1:0];
    return v[EST_W-1:0];
  endfunction

  // one predict/update step on the local state
  task automatic kalman_update(input logic signed [15:0] m, output filter_result_t res);
    longint          sample_fx;
    longint          diff;
    longint          delta;
    longint unsigned p_pred;
    longint unsigned den;
    longint unsigned k;
    longint unsigned p_new;
    sample_fx = clamp_est(longint'(m) <<< FRAC);
    p_pred = 64'(cov_state) + 64'(proc_noise);
    if (p_pred > COV_MAX) p_pred = COV_MAX;
    den = p_pred + 64'(meas_noise);
    k = (den == 0) ? 64'd0 : (p_pred << GAIN_BITS) / den;
    if (k > 64'(GAIN_ONE)) k = 64'(GAIN_ONE);
    diff = sample_fx - longint'(est_state);
    // arithmetic shift gives floor rounding of the correction
    delta = (longint'(k) * diff) >>> GAIN_BITS;
    est_state = clamp_est(longint'(est_state) + delta);
    p_new = ((64'(GAIN_ONE) - k) * p_pred) >> GAIN_BITS;
    if (p_new > COV_MAX) p_new = COV_MAX;
    cov_state = p_new[COV_W-1:0];
    res.estimate   = est_state;
    res.gain       = k[GAIN_W-1:0];
    res.covariance = cov_state;
  endtask

  always @(posedge clk) begin
    filter_result_t want;
    filter_result_t got;
    if (!rst_n) begin
      proc_noise = RST_PROC_NOISE;
      meas_noise = RST_MEAS_NOISE;
      cov_state  = RST_INIT_COV;
      est_state  = RST_INIT_EST;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_index)
          REG_PROC_NOISE: proc_noise = cfg_wdata;
          REG_MEAS_NOISE: meas_noise = cfg_wdata;
          REG_INIT_COV:   cov_state  = cfg_wdata;
          REG_INIT_EST:   est_state  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: estimate %0d gain %0d covariance %0d",
                   $time, out_estimate, out_gain, out_covariance);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_estimate !== want.estimate) begin
            $display("%0t: estimate mismatch, expected %0d, got %0d",
                     $time, want.estimate, out_estimate);
            error_count++;
          end
          if (out_gain !== want.gain) begin
            $display("%0t: gain mismatch, expected %0d, got %0d", $time, want.gain, out_gain);
            error_count++;
          end
          if (out_covariance !== want.covariance) begin
            $display("%0t: covariance mismatch, expected %0d, got %0d",
                     $time, want.covariance, out_covariance);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        kalman_update(in_measurement, got);
        expected_results.push_back(got);
      end
    end
    mismatches  <= error_count;
    outstanding <= expected_results.size();
  end

endmodule

// ===== sim/scalar_kalman_filter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top_tb
// Drives samples and register writes into the scalar Kalman filter with
// random gaps on both sides, a long receiver hold-off and a full drain, over
// directed corner settings and random register settings. The result check
// sits beside the block; this module gives the verdict.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top_tb;
  import skf_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_PAUSE     = 30;
  localparam int MAX_GAP         = 13;

  // indexes outside the register list, writes are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 8'hFF;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   stall_cycles = 0;
  int   hold_request = 0;
  bit   idle_on = 1'b1;

  always #1 clk = ~clk;

  skf_in_if #(.SAMPLE_BITS(16)) in_ch();
  skf_out_if                    out_ch();
  skf_cfg_if                    cfg_ch();

  scalar_kalman_filter_top #(
    .SAMPLE_BITS(16),
    .FRAC_BITS  (16)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  skf_result_check result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_measurement(in_ch.measurement),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_estimate  (out_ch.estimate),
    .out_gain      (out_ch.gain),
    .out_covariance(out_ch.covariance),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_reg_index (cfg_ch.reg_index),
    .cfg_wdata     (cfg_ch.wdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 255);
      3, 4:    return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(input logic signed [15:0] m, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.measurement <= m;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] q, input logic [31:0] r,
                           input logic [31:0] p0, input logic [31:0] x0);
    drain();
    cfg_write(REG_PROC_NOISE, q);
    cfg_write(REG_MEAS_NOISE, r);
    cfg_write(REG_INIT_COV, p0);
    cfg_write(REG_INIT_EST, x0);
  endtask

  // receiver: random stalls, plus the long hold-off when requested
  initial begin
    int gap;
    bit hold_taken;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (hold_request > 0 && !hold_taken) begin
        gap = hold_request;
        hold_taken = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int          base;
    int          span;
    int          v;
    logic [31:0] x0;
    in_ch.valid       <= 1'b0;
    in_ch.measurement <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.reg_index  <= '0;
    cfg_ch.wdata      <= '0;
    rst_n             <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // writes outside the list must leave the defaults alone
    cfg_write(REG_UNUSED_LAST, $urandom);
    cfg_write(REG_UNUSED_FIRST, $urandom);
    send_sample(16'sd0, draw_gap());
    send_sample(16'sd32767, draw_gap());
    send_sample(-16'sd32768, draw_gap());
    send_sample(-16'sd1, draw_gap());
    send_sample(16'sd1, draw_gap());
    send_sample(16'sh5555, draw_gap());
    send_sample(16'shAAAA, draw_gap());
    send_sample(16'sd32767, 0);
    send_sample(16'sd32767, 0);

    // zero denominator
    configure(32'h0, 32'h0, 32'h0, 32'h0);
    send_sample(16'sd100, draw_gap());
    send_sample(-16'sd100, draw_gap());

    // predicted covariance saturates, unity gain
    configure(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_sample(-16'sd32768, draw_gap());
    send_sample(16'sd32767, draw_gap());

    // very small gain from the most negative estimate
    configure(32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000);
    send_sample(16'sd32767, draw_gap());
    send_sample(-16'sd32768, draw_gap());
    send_sample(16'sd0, draw_gap());

    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    send_sample(16'sd1, 0);
    send_sample(16'sd1, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p % 3 != 1);
      base = $urandom_range(0, 65535) - 32768;
      span = 1 << $urandom_range(0, 12);
      x0 = $urandom_range(0, 1) ? pick_word() : {base[15:0], 16'($urandom)};
      configure(pick_word(), pick_word(), pick_word(), x0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 2 && i == 10) hold_request = HOLD_CYCLES;
        if (p == 4 && i == 50) drain();
        // mostly a slowly moving signal with noise, now and then a wild sample
        if ($urandom_range(0, 9) < 2) begin
          v = $urandom_range(0, 65535) - 32768;
        end else begin
          base = base + $urandom_range(0, 6) - 3;
          v = base + $urandom_range(0, 2 * span) - span;
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        if (base > 32767) base = 32767;
        if (base < -32768) base = -32768;
        send_sample(16'(v), draw_gap());
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/skf_pkg.sv
design/skf_in_if.sv
design/skf_out_if.sv
design/skf_cfg_if.sv
design/skf_seq.sv
design/skf_dp.sv
design/scalar_kalman_filter_top.sv
sim/skf_result_check.sv
sim/scalar_kalman_filter_top_tb.sv
